// ----- src/indexed_image_rle_decoder_unit_defines.svh -----
// Assertion helpers for the decoder modules; iird_decode is the one that includes them.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef INDEXED_IMAGE_RLE_DECODER_UNIT_DEFINES_SVH
`define INDEXED_IMAGE_RLE_DECODER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define IIRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define IIRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/iird_pkg.sv -----
package iird_pkg;

    // Dimension handling
    localparam int                 DIM_W   = 13;
    localparam logic [DIM_W-1:0]   MAX_DIM = 13'd4096;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // Register indexes of the configuration port
    localparam int                CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd3;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_CTRL  = 3'b001,
        PH_VALUE = 3'b010,
        PH_LIT   = 3'b100
    } t_phase;

    // Software-written settings
    typedef struct packed {
        logic              decode_mode;
        logic [BYTE_W-1:0] key_index;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
    } t_cfg;

    // One decoded run
    typedef struct packed {
        logic              overrun;
        logic              image_end;
        logic              row_end;
        logic [LEN_W-1:0]  run_length;
        logic [BYTE_W-1:0] pixel_value;
    } t_run;

    // Sizes above the supported maximum act as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

endpackage

// ----- src/iird_in_stage.sv -----
module iird_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [iird_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_take,
    output logic                       o_valid,
    output logic [iird_pkg::BYTE_W-1:0] o_byte
);
    import iird_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // Room when empty or when the held byte leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ----- src/iird_decode.sv -----
module iird_decode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  iird_pkg::t_cfg              i_cfg,
    input  logic                        i_fire,
    input  logic [iird_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_emit,
    output iird_pkg::t_run              o_run
);
    import iird_pkg::*;

    `include "indexed_image_rle_decoder_unit_defines.svh"

    t_phase           r_phase,  n_phase;
    logic [LEN_W-1:0] r_count,  n_count;
    logic [DIM_W-1:0] r_column, n_column;
    logic [DIM_W-1:0] r_row,    n_row;
    logic             r_finished, n_finished;

    logic [DIM_W-1:0]  w_width, w_height;
    logic              w_ignore;
    logic              w_emit, w_may_close, w_closes, w_last, w_over;
    logic [BYTE_W-1:0] w_value;
    logic [LEN_W-1:0]  w_len;
    logic [DIM_W:0]    w_ncol;

    assign w_width  = clamp_dim(i_cfg.image_width);
    assign w_height = clamp_dim(i_cfg.image_height);
    assign w_ignore = r_finished || (r_row >= w_height);

    // Parser step and column / row tracking
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_column    = r_column;
        n_row       = r_row;
        n_finished  = r_finished;
        w_emit      = 1'b0;
        w_value     = i_byte;
        w_len       = LEN_W'(1);
        w_may_close = 1'b1;
        w_closes    = 1'b0;
        w_last      = 1'b0;
        w_over      = 1'b0;
        w_ncol      = '0;
        if (i_fire && !w_ignore) begin
            case (r_phase)
                PH_VALUE: begin
                    n_phase = PH_CTRL;
                    n_count = '0;
                    w_len   = r_count;
                    w_emit  = (r_count != '0);
                end
                PH_LIT: begin
                    n_count     = r_count - LEN_W'(1);
                    w_emit      = 1'b1;
                    w_may_close = (n_count == '0);
                    if (n_count == '0) begin
                        n_phase = PH_CTRL;
                    end
                end
                default: begin
                    // control byte; unused codes land here too
                    n_phase = PH_CTRL;
                    if (!i_cfg.decode_mode) begin
                        if (i_byte[7:6] == 2'b11) begin
                            n_phase = PH_VALUE;
                            n_count = {1'b0, i_byte[5:0]};
                        end else begin
                            w_emit = 1'b1;
                        end
                    end else if (i_byte[7]) begin
                        w_value = i_cfg.key_index;
                        w_len   = i_byte[6:0];
                        w_emit  = (i_byte[6:0] != '0);
                    end else if (i_byte != '0) begin
                        n_phase = PH_LIT;
                        n_count = i_byte[6:0];
                    end
                end
            endcase

            if (w_emit) begin
                w_ncol   = {1'b0, r_column} + {{(DIM_W+1-LEN_W){1'b0}}, w_len};
                w_over   = w_ncol > {1'b0, w_width};
                w_closes = w_may_close && (w_ncol >= {1'b0, w_width});
                if (w_closes) begin
                    n_column = '0;
                    n_row    = r_row + DIM_W'(1);
                    if (n_row >= w_height) begin
                        w_last     = 1'b1;
                        n_finished = 1'b1;
                        n_phase    = PH_CTRL;
                        n_count    = '0;
                    end
                end else begin
                    n_column = w_ncol[DIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CTRL;
            r_count    <= '0;
            r_column   <= '0;
            r_row      <= '0;
            r_finished <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_column   <= n_column;
            r_row      <= n_row;
            r_finished <= n_finished;
        end
    end

    assign o_emit            = w_emit;
    assign o_run.pixel_value = w_value;
    assign o_run.run_length  = w_len;
    assign o_run.row_end     = w_closes;
    assign o_run.image_end   = w_last;
    assign o_run.overrun     = w_over;

    // Checks
    `IIRD_ASSERT(a_fin_idle, !r_finished || (r_phase == PH_CTRL && r_count == '0), "finished parser not idle")
    `IIRD_ASSERT(a_lit_count, r_phase != PH_LIT || r_count != '0, "literal phase with zero count")
    `IIRD_ASSERT(a_col_bound, r_column < (MAX_DIM + DIM_W'(127)), "column out of range")
    `IIRD_ASSERT_NEXT(a_fin_hold, r_finished, r_finished && r_row == $past(r_row), "finished state left")

endmodule

// ----- src/iird_out_stage.sv -----
module iird_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  iird_pkg::t_run i_run,
    input  logic           i_ready,
    output logic           o_free,
    output logic           o_valid,
    output iird_pkg::t_run o_run
);
    import iird_pkg::*;

    logic r_valid;
    t_run r_run;

    // Free when empty or when the held run is taken this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_run <= i_run;
        end
    end

    assign o_valid = r_valid;
    assign o_run   = r_run;

endmodule

// ----- src/indexed_image_rle_decoder_unit.sv -----
// Channel    Dir  Data                                   Side band
// s_axis     in   tdata[7:0] data_byte                   -
// m_axis     out  tdata[7:0] pixel_value, [14:8] len     tlast row_end, tuser image_end/overrun
// cfg        in   wdata per index: mode, key, width, height  write only
//
// One compressed byte per cycle, sustained while the output is not stalled; the run of a byte
// enters the output register when the byte leaves the input register through the parser step.
// The parser state update between the two registers sets the rate.
// Synchronous active-low reset clears parser, position and both stage valids.
// A stalled output holds its run; input keeps flowing until both registers are full.
module indexed_image_rle_decoder_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,   // [7:0] data_byte
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [15:0]                    o_m_axis_tdata,   // [7:0] pixel_value, [14:8] run_length
    output logic                           o_m_axis_tlast,   // row_end
    output logic [1:0]                     o_m_axis_tuser,   // [0] image_end, [1] overrun
    input  logic                           i_cfg_wr_en,
    input  logic [iird_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [iird_pkg::DIM_W-1:0]     i_cfg_wdata
);
    import iird_pkg::*;

    t_cfg              r_cfg;
    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_byte;
    logic              w_out_free;
    logic              w_fire;
    logic              w_emit;
    t_run              w_run;
    t_run              w_out_run;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decode_mode  <= 1'b0;
            r_cfg.key_index    <= '0;
            r_cfg.image_width  <= DIM_W'(1);
            r_cfg.image_height <= DIM_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MODE:   r_cfg.decode_mode  <= i_cfg_wdata[0];
                CFG_KEY:    r_cfg.key_index    <= i_cfg_wdata[BYTE_W-1:0];
                CFG_WIDTH:  r_cfg.image_width  <= i_cfg_wdata;
                CFG_HEIGHT: r_cfg.image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A byte advances when the output register can take a possible run
    assign w_fire = w_in_valid && w_out_free;

    iird_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    iird_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_fire  (w_fire),
        .i_byte  (w_in_byte),
        .o_emit  (w_emit),
        .o_run   (w_run)
    );

    iird_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_emit),
        .i_run   (w_run),
        .i_ready (i_m_axis_tready),
        .o_free  (w_out_free),
        .o_valid (o_m_axis_tvalid),
        .o_run   (w_out_run)
    );

    assign o_m_axis_tdata = {1'b0, w_out_run.run_length, w_out_run.pixel_value};
    assign o_m_axis_tlast = w_out_run.row_end;
    assign o_m_axis_tuser = {w_out_run.overrun, w_out_run.image_end};

endmodule
